// ----- design/mctps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctps_pkg
// shared constants for the multi-channel trigger pulse sequencer
// ----------------------------------------------------------------------------
package mctps_pkg;

  // channel layout
  localparam int NUM_CHANNELS   = 8;
  localparam int CLAP_CHANNEL   = 4;
  localparam int ACCENT_CHANNEL = 6;

  // field widths
  localparam int CMD_W   = 3;
  localparam int CHAN_W  = 4;
  localparam int TIMER_W = 7;
  localparam int LINES_W = 8;
  localparam int PHASE_W = 3;
  localparam int CLAP_W  = 4;
  localparam int LEVEL_W = 1 << CHAN_W;
  localparam int IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // stream and config widths
  localparam int S_TDATA_W = 8;
  localparam int S_TUSER_W = CMD_W;
  localparam int M_TDATA_W = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;

  // clap channel presence and a safe index into the timer array
  localparam bit HAS_CLAP = (CLAP_CHANNEL < NUM_CHANNELS);
  localparam int CLAP_IDX = HAS_CLAP ? CLAP_CHANNEL : 0;
  localparam bit CLAP_VISIBLE = (CLAP_CHANNEL < LINES_W);

  // register reset values
  localparam logic [TIMER_W-1:0] PULSE_RESET = 7'd10;
  localparam logic [TIMER_W-1:0] GAP_RESET   = 7'd90;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 4'd1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PLAY       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STEP       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACCENT_ON  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ACCENT_OFF = 3'd4;

  // channel machine phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_START = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CLAP  = 3'd4;

  // clap sequence phases
  localparam logic [CLAP_W-1:0] CL_IDLE  = 4'd0;
  localparam logic [CLAP_W-1:0] CL_START = 4'd1;
  localparam logic [CLAP_W-1:0] CL_A1    = 4'd2;
  localparam logic [CLAP_W-1:0] CL_GAP1  = 4'd3;
  localparam logic [CLAP_W-1:0] CL_A2    = 4'd4;
  localparam logic [CLAP_W-1:0] CL_GAP2  = 4'd5;
  localparam logic [CLAP_W-1:0] CL_A3    = 4'd6;
  localparam logic [CLAP_W-1:0] CL_GAP3  = 4'd7;
  localparam logic [CLAP_W-1:0] CL_B     = 4'd8;

endpackage

// ----- design/multi_channel_trigger_pulse_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_trigger_pulse_sequencer
// per-channel trigger pulse generator with a three-plus-one clap sequence
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command request: tuser holds the command code, tdata
//   the channel number for play. every accepted request updates the channel
//   state at once and yields exactly one result on m_axis: the trigger lines,
//   both clap lines and an all-idle flag, as seen after the request.
//   cfg carries register writes (index 0 pulse_ticks, index 1 gap_ticks);
//   it is always ready, unknown indexes are dropped. write only while idle.
// throughput and output register
//   one request per clock while m_axis takes results. a result shows up on m_axis
//   in the cycle after its request is taken, held in the single result register.
// stall
//   while a result sits in the output register and m_axis_tready is low,
//   s_axis_tready drops; when the result is taken the next request can be
//   accepted in that same cycle, so a steady stream runs at full rate.
// reset
//   rst_ni low clears all machines to idle, timers and lines to zero and
//   loads the register defaults (pulse 10, gap 90); m_axis goes empty.
// ----------------------------------------------------------------------------
module multi_channel_trigger_pulse_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command requests
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mctps_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [3:0] channel, [7:4] zero
  input  logic [mctps_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [2:0] cmd
  // results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] trigger_lines, [8] clap_line_a, [9] clap_line_b, [10] all_idle, [15:11] zero
  output logic [mctps_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mctps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mctps_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  localparam int NCH = mctps_pkg::NUM_CHANNELS;
  localparam int TW  = mctps_pkg::TIMER_W;

  // configuration registers
  logic [TW-1:0] pulse_q, gap_q;

  // channel state
  logic [mctps_pkg::PHASE_W-1:0] phase_q [NCH];
  logic [mctps_pkg::PHASE_W-1:0] phase_d [NCH];
  logic [TW-1:0]                 timer_q [NCH];
  logic [TW-1:0]                 timer_d [NCH];
  logic [mctps_pkg::CLAP_W-1:0]  clap_q, clap_d;
  logic [mctps_pkg::LEVEL_W-1:0] lvl_q, lvl_d;
  logic                          clap_a_q, clap_a_d;
  logic                          clap_b_q, clap_b_d;

  // output register
  logic                            out_valid_q;
  logic [mctps_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;

  logic                           in_fire;
  logic [mctps_pkg::CMD_W-1:0]    cmd;
  logic [mctps_pkg::CHAN_W-1:0]   chan;
  logic                           all_idle;
  logic [mctps_pkg::LINES_W-1:0]  lines;

  assign cmd  = s_axis_tuser[mctps_pkg::CMD_W-1:0];
  assign chan = s_axis_tdata[mctps_pkg::CHAN_W-1:0];

  // output register frees up in the same cycle it is drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // next state for one request
  always_comb begin
    phase_d  = phase_q;
    timer_d  = timer_q;
    clap_d   = clap_q;
    lvl_d    = lvl_q;
    clap_a_d = clap_a_q;
    clap_b_d = clap_b_q;

    case (cmd)
      mctps_pkg::CMD_PLAY: begin
        // out-of-range channels are ignored, a busy channel restarts
        if ({1'b0, chan} < (mctps_pkg::CHAN_W+1)'(NCH)) begin
          phase_d[chan[mctps_pkg::IDX_W-1:0]] = mctps_pkg::PH_START;
        end
      end
      mctps_pkg::CMD_TICK: begin
        for (int i = 0; i < NCH; i++) begin
          if (timer_q[i] != '0) begin
            timer_d[i] = timer_q[i] - TW'(1);
          end
        end
      end
      mctps_pkg::CMD_STEP: begin
        // channels touch only their own state, so the pass runs in parallel
        for (int i = 0; i < NCH; i++) begin
          case (phase_q[i])
            mctps_pkg::PH_START: begin
              if (mctps_pkg::HAS_CLAP && i == mctps_pkg::CLAP_CHANNEL) begin
                clap_d     = mctps_pkg::CL_START;
                phase_d[i] = mctps_pkg::PH_CLAP;
              end else begin
                lvl_d[i]   = 1'b1;
                timer_d[i] = pulse_q;
                phase_d[i] = mctps_pkg::PH_WAIT;
              end
            end
            mctps_pkg::PH_WAIT: begin
              if (timer_q[i] == '0) begin
                lvl_d[i]   = 1'b0;
                phase_d[i] = mctps_pkg::PH_DONE;
              end
            end
            mctps_pkg::PH_DONE: begin
              phase_d[i] = mctps_pkg::PH_IDLE;
            end
            default: begin
            end
          endcase
        end

        // clap sequence, driven by the clap channel's own timer
        if (mctps_pkg::HAS_CLAP && phase_q[mctps_pkg::CLAP_IDX] == mctps_pkg::PH_CLAP) begin
          case (clap_q)
            mctps_pkg::CL_START: begin
              clap_a_d = 1'b1;
              timer_d[mctps_pkg::CLAP_IDX] = pulse_q;
              clap_d = mctps_pkg::CL_A1;
            end
            mctps_pkg::CL_A1, mctps_pkg::CL_A2, mctps_pkg::CL_A3: begin
              if (timer_q[mctps_pkg::CLAP_IDX] == '0) begin
                clap_a_d = 1'b0;
                timer_d[mctps_pkg::CLAP_IDX] = gap_q;
                clap_d = clap_q + mctps_pkg::CLAP_W'(1);
              end
            end
            mctps_pkg::CL_GAP1, mctps_pkg::CL_GAP2: begin
              if (timer_q[mctps_pkg::CLAP_IDX] == '0) begin
                clap_a_d = 1'b1;
                timer_d[mctps_pkg::CLAP_IDX] = pulse_q;
                clap_d = clap_q + mctps_pkg::CLAP_W'(1);
              end
            end
            mctps_pkg::CL_GAP3: begin
              if (timer_q[mctps_pkg::CLAP_IDX] == '0) begin
                clap_b_d = 1'b1;
                timer_d[mctps_pkg::CLAP_IDX] = pulse_q;
                clap_d = mctps_pkg::CL_B;
              end
            end
            mctps_pkg::CL_B: begin
              if (timer_q[mctps_pkg::CLAP_IDX] == '0) begin
                clap_b_d = 1'b0;
                clap_d   = mctps_pkg::CL_IDLE;
                phase_d[mctps_pkg::CLAP_IDX] = mctps_pkg::PH_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mctps_pkg::CMD_ACCENT_ON: begin
        lvl_d[mctps_pkg::ACCENT_CHANNEL] = 1'b1;
      end
      mctps_pkg::CMD_ACCENT_OFF: begin
        lvl_d[mctps_pkg::ACCENT_CHANNEL] = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // result as seen after the request
  always_comb begin
    all_idle = 1'b1;
    for (int i = 0; i < NCH; i++) begin
      if (phase_d[i] != mctps_pkg::PH_IDLE) begin
        all_idle = 1'b0;
      end
    end
    lines = lvl_d[mctps_pkg::LINES_W-1:0];
    if (mctps_pkg::CLAP_VISIBLE) begin
      lines[mctps_pkg::CLAP_CHANNEL % mctps_pkg::LINES_W] = 1'b0;
    end
    out_data_d = {5'd0, all_idle, clap_b_d, clap_a_d, lines};
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= mctps_pkg::PULSE_RESET;
      gap_q   <= mctps_pkg::GAP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mctps_pkg::REG_PULSE_TICKS: pulse_q <= cfg_data_i[TW-1:0];
        mctps_pkg::REG_GAP_TICKS:   gap_q   <= cfg_data_i[TW-1:0];
        default: begin
        end
      endcase
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        phase_q[i] <= mctps_pkg::PH_IDLE;
        timer_q[i] <= '0;
      end
      clap_q   <= mctps_pkg::CL_IDLE;
      lvl_q    <= '0;
      clap_a_q <= 1'b0;
      clap_b_q <= 1'b0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      timer_q  <= timer_d;
      clap_q   <= clap_d;
      lvl_q    <= lvl_d;
      clap_a_q <= clap_a_d;
      clap_b_q <= clap_b_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule
